### rtl/overwriting_ring_buffer_deque_defines.svh
// Assertion macros for the overwriting ring buffer deque.
`ifndef OVERWRITING_RING_BUFFER_DEQUE_DEFINES_SVH
`define OVERWRITING_RING_BUFFER_DEQUE_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define ORBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset.
`define ORBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/orbd_pkg.sv
// Shared types and constants for the overwriting ring buffer deque.
package orbd_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam int CAP_RESET_VAL = 16;
  localparam int WORD_W        = 32;

  localparam logic [1:0] MODE_PUSH      = 2'd0;
  localparam logic [1:0] MODE_POP_FRONT = 2'd1;
  localparam logic [1:0] MODE_POP_BACK  = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic                     status;
    logic                     overwrote;
    logic                     now_empty;
    logic                     now_full;
  } rsp_t;

endpackage

### rtl/overwriting_ring_buffer_deque.sv
// Top level of the overwriting ring buffer deque: pointers, flags and entry RAM.
// Each accepted request gives its result, strobed by done, in the cycle
// after acceptance, through the registered RAM read and result flags.
// Throughput: one request per cycle while busy is low; busy is high during reset and capacity writes.
// Reset: synchronous; clears pointers and full flag, sets capacity to its
// default; entry RAM contents stay undefined until written.
`include "overwriting_ring_buffer_deque_defines.svh"

module overwriting_ring_buffer_deque #(
  parameter int DEPTH = orbd_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  orbd_pkg::req_t                req,
  output logic                          done,
  output orbd_pkg::rsp_t                rsp,
  input  logic                          cfg_we,
  input  logic [orbd_pkg::CAP_W-1:0]    cfg_wdata
);

  localparam int CAP_W = orbd_pkg::CAP_W;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RESET =
    CAP_W'((DEPTH < orbd_pkg::CAP_RESET_VAL) ? DEPTH : orbd_pkg::CAP_RESET_VAL);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] c);
    logic [PW-1:0] s;
    s = PW'(i) + PW'(1);
    return (s >= PW'(c)) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] c);
    logic [PW-1:0] s;
    s = PW'(c) - PW'(1);
    return (i == '0) ? s[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] back, back_next;
  logic             full, full_next;
  logic [CAP_W-1:0] cap, cap_next;

  logic             accept;
  logic             empty;
  logic             we;
  logic [IDX_W-1:0] raddr;
  logic             pop_hit, pop_hit_next;
  logic             status_next, ovw_next;
  logic [PW-1:0]    cfg_ext;
  logic [orbd_pkg::WORD_W-1:0] rdata;

  logic pop_hit_q, status_q, ovw_q, empty_q, full_q;

  assign busy   = rst || cfg_we;
  assign accept = start && !busy;
  assign empty  = !full && (front == back);

  always_comb begin
    front_next   = front;
    back_next    = back;
    full_next    = full;
    we           = 1'b0;
    raddr        = front;
    pop_hit_next = 1'b0;
    status_next  = 1'b0;
    ovw_next     = 1'b0;
    if (accept) begin
      unique case (req.mode)
        orbd_pkg::MODE_PUSH: begin
          if (full) begin
            front_next = ring_next(front, cap);
            ovw_next   = 1'b1;
          end
          we        = 1'b1;
          back_next = ring_next(back, cap);
          full_next = (back_next == front_next);
        end
        orbd_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            status_next = 1'b1;
          end else begin
            raddr        = front;
            pop_hit_next = 1'b1;
            front_next   = ring_next(front, cap);
            full_next    = 1'b0;
          end
        end
        orbd_pkg::MODE_POP_BACK: begin
          if (empty) begin
            status_next = 1'b1;
          end else begin
            back_next    = ring_prev(back, cap);
            raddr        = back_next;
            pop_hit_next = 1'b1;
            full_next    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pop_hit = pop_hit_next;

  always_comb begin
    cfg_ext = PW'(cfg_wdata);
    if (cfg_ext == '0) begin
      cap_next = CAP_W'(1);
    end else if (cfg_ext > PW'(DEPTH)) begin
      cap_next = CAP_W'(DEPTH);
    end else begin
      cap_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      full  <= 1'b0;
      cap   <= CAP_RESET;
      done  <= 1'b0;
    end else if (cfg_we) begin
      front <= '0;
      back  <= '0;
      full  <= 1'b0;
      cap   <= cap_next;
      done  <= 1'b0;
    end else begin
      front <= front_next;
      back  <= back_next;
      full  <= full_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pop_hit_q <= pop_hit;
    status_q  <= status_next;
    ovw_q     <= ovw_next;
    empty_q   <= !full_next && (front_next == back_next);
    full_q    <= full_next;
  end

  orbd_ram #(
    .WIDTH(orbd_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(back),
    .wdata(req.push_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    rsp.pop_value = pop_hit_q ? $signed(rdata) : '0;
    rsp.status    = status_q;
    rsp.overwrote = ovw_q;
    rsp.now_empty = empty_q;
    rsp.now_full  = full_q;
  end

  `ORBD_ASSERT_NOW(a_done_follows_accept, clk, rst, 1'b1, done == $past(accept),
    "result strobe does not match previous request")
  `ORBD_ASSERT_NOW(a_ptr_in_range, clk, rst, 1'b1,
    (PW'(front) < PW'(cap)) && (PW'(back) < PW'(cap)), "pointer beyond capacity")
  `ORBD_ASSERT_NOW(a_full_ptrs_meet, clk, rst, full, front == back,
    "full flag set with pointers apart")
  `ORBD_ASSERT_NEXT(a_cfg_empties, clk, rst, cfg_we, !full && (front == back),
    "capacity write did not empty buffer")
  `ORBD_ASSERT_NOW(a_empty_pop_zero, clk, rst, done && rsp.status,
    (rsp.pop_value == '0) && !rsp.overwrote && rsp.now_empty,
    "failed pop returned data or wrong flags")

endmodule

### rtl/orbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module orbd_ram #(
  parameter int WIDTH = orbd_pkg::WORD_W,
  parameter int DEPTH = orbd_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/overwriting_ring_buffer_deque_test.sv
// Self-checking testbench for the overwriting ring buffer deque.
`timescale 1ns / 1ps

module overwriting_ring_buffer_deque_test;

  localparam int RING_DEPTH = orbd_pkg::DEPTH_DEFAULT;
  localparam int WORD_W = orbd_pkg::WORD_W;
  localparam int CAP_W = orbd_pkg::CAP_W;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  orbd_pkg::req_t req = '0;
  logic done;
  orbd_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  logic signed [WORD_W-1:0] ring_words [RING_DEPTH];
  logic [IDX_W-1:0] ring_front;
  logic [IDX_W-1:0] ring_back;
  logic ring_full;
  logic [CAP_W-1:0] ring_capacity;

  orbd_pkg::rsp_t results_due [$];
  int faults = 0;
  int cycle_count = 0;

  overwriting_ring_buffer_deque #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] i);
    logic [CAP_W-1:0] n;
    n = CAP_W'(i) + 1'b1;
    return (n >= ring_capacity) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(logic [IDX_W-1:0] i);
    logic [CAP_W-1:0] last;
    last = ring_capacity - 1'b1;
    return (i == '0) ? last[IDX_W-1:0] : i - 1'b1;
  endfunction

  function automatic logic ring_is_empty();
    return !ring_full && ring_front == ring_back;
  endfunction

  function automatic void set_ring_capacity(logic [CAP_W-1:0] code);
    if (code == '0) ring_capacity = CAP_W'(1);
    else if (code > RING_DEPTH) ring_capacity = CAP_W'(RING_DEPTH);
    else ring_capacity = code;
    ring_front = '0;
    ring_back = '0;
    ring_full = 1'b0;
  endfunction

  function automatic orbd_pkg::rsp_t ring_apply(orbd_pkg::req_t r);
    orbd_pkg::rsp_t o;
    o = '0;
    case (r.mode)
      orbd_pkg::MODE_PUSH: begin
        if (ring_full) begin
          ring_front = next_slot(ring_front);
          o.overwrote = 1'b1;
        end
        ring_words[ring_back] = r.push_value;
        ring_back = next_slot(ring_back);
        if (ring_back == ring_front) ring_full = 1'b1;
      end
      orbd_pkg::MODE_POP_FRONT, orbd_pkg::MODE_POP_BACK: begin
        if (ring_is_empty()) begin
          o.status = 1'b1;
        end else if (r.mode == orbd_pkg::MODE_POP_FRONT) begin
          o.pop_value = ring_words[ring_front];
          ring_front = next_slot(ring_front);
          ring_full = 1'b0;
        end else begin
          ring_back = prev_slot(ring_back);
          o.pop_value = ring_words[ring_back];
          ring_full = 1'b0;
        end
      end
      default: ;
    endcase
    o.now_empty = ring_is_empty();
    o.now_full = ring_full;
    return o;
  endfunction

  function automatic orbd_pkg::req_t make_req(logic [1:0] mode,
                                              logic signed [WORD_W-1:0] value);
    orbd_pkg::req_t r;
    r.mode = mode;
    r.push_value = value;
    return r;
  endfunction

  task automatic send_request(orbd_pkg::req_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    results_due.push_back(ring_apply(r));
  endtask

  task automatic drain_ring();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] code);
    drain_ring();
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_ring_capacity(code);
  endtask

  task automatic check_field(string name, logic signed [WORD_W-1:0] want,
                             logic signed [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : check_results
    orbd_pkg::rsp_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result with no request outstanding");
        faults++;
      end else begin
        want = results_due.pop_front();
        check_field("pop_value", want.pop_value, rsp.pop_value);
        check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
        check_field("overwrote", WORD_W'(want.overwrote), WORD_W'(rsp.overwrote));
        check_field("now_empty", WORD_W'(want.now_empty), WORD_W'(rsp.now_empty));
        check_field("now_full", WORD_W'(want.now_full), WORD_W'(rsp.now_full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("overwriting_ring_buffer_deque regression: fail");
      $finish;
    end
  end

  task automatic test_empty_and_extremes();
    send_request(make_req(orbd_pkg::MODE_POP_FRONT, WORD_MAX), 0);
    send_request(make_req(orbd_pkg::MODE_POP_BACK, -1), 0);
    send_request(make_req(MODE_UNUSED, 0), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, WORD_MAX), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, WORD_MIN), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, 0), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, -1), 0);
    send_request(make_req(MODE_UNUSED, WORD_MIN), 0);
    send_request(make_req(orbd_pkg::MODE_POP_BACK, 0), 0);
    send_request(make_req(orbd_pkg::MODE_POP_FRONT, 0), 0);
    send_request(make_req(orbd_pkg::MODE_POP_FRONT, 0), 1);
    send_request(make_req(orbd_pkg::MODE_POP_BACK, 0), 0);
    send_request(make_req(orbd_pkg::MODE_POP_FRONT, 0), 0);
  endtask

  task automatic test_capacity_one();
    write_capacity('0);
    send_request(make_req(orbd_pkg::MODE_PUSH, 5), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, -7), 0);
    send_request(make_req(MODE_UNUSED, 0), 0);
    send_request(make_req(orbd_pkg::MODE_POP_BACK, 0), 0);
    send_request(make_req(orbd_pkg::MODE_POP_FRONT, 0), 0);
    send_request(make_req(orbd_pkg::MODE_PUSH, WORD_MIN), 2);
  endtask

  task automatic run_ring_phase(logic [CAP_W-1:0] code, int n_items);
    int push_pct;
    bit no_gaps;
    int pick;
    int gap;
    logic [1:0] mode;
    logic signed [WORD_W-1:0] value;
    write_capacity(code);
    push_pct = $urandom_range(35, 75);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) mode = MODE_UNUSED;
      else if (pick < 3 + push_pct) mode = orbd_pkg::MODE_PUSH;
      else if ($urandom_range(0, 1) == 0) mode = orbd_pkg::MODE_POP_FRONT;
      else mode = orbd_pkg::MODE_POP_BACK;
      case ($urandom_range(0, 19))
        0: value = WORD_MAX;
        1: value = WORD_MIN;
        2: value = 0;
        3: value = -1;
        default: value = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      send_request(make_req(mode, value), gap);
    end
  endtask

  task automatic test_random_phases();
    logic [CAP_W-1:0] codes [$];
    codes = '{5'd1, 5'd0, 5'd2, 5'd16, 5'd17, 5'd31, 5'd3, 5'd15};
    repeat (7) codes.push_back(CAP_W'($urandom_range(0, 31)));
    foreach (codes[i]) run_ring_phase(codes[i], $urandom_range(90, 140));
  endtask

  initial begin
    set_ring_capacity(CAP_W'(orbd_pkg::CAP_RESET_VAL));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_capacity_one();
    test_random_phases();
    drain_ring();
    repeat (4) @(posedge clk);
    if (faults == 0) begin
      $display("overwriting_ring_buffer_deque regression: pass");
    end else begin
      $display("overwriting_ring_buffer_deque regression: fail");
    end
    $finish;
  end

endmodule
